FILE: rtl/keyframe_vector_lerp_assert.svh
// Assertion macros for the keyframe interpolator and its port checker.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef KEYFRAME_VECTOR_LERP_ASSERT_SVH
`define KEYFRAME_VECTOR_LERP_ASSERT_SVH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define KVL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyframe_vector_lerp: assertion failed");
// Next-cycle implication.
`define KVL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyframe_vector_lerp: assertion failed");
`endif

FILE: rtl/kvl_pkg.sv
// Shared types and constants of the keyframe interpolator.
// No dependencies.
`timescale 1ns / 1ps
package kvl_pkg;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned IdxWidth  = 6;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned BlendWidth = 17;
  localparam int unsigned CountWidth = 7;

  // One classified word from the input queue.
  typedef struct packed {
    logic                 is_sample;
    logic                 slot_ok;
    logic [IdxWidth-1:0]  idx;
    logic [DataWidth-1:0] tm;
    logic [DataWidth-1:0] x;
    logic [DataWidth-1:0] y;
    logic [DataWidth-1:0] z;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [DataWidth-1:0]  x;
    logic [DataWidth-1:0]  y;
    logic [DataWidth-1:0]  z;
    logic [IdxWidth-1:0]   seg;
    logic [BlendWidth-1:0] blend;
  } res_t;
endpackage

FILE: rtl/kvl_front.sv
// Input side: two-word queue that classifies each accepted word.
// Depends on kvl_pkg.
`timescale 1ns / 1ps
module kvl_front #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 req_type_i,
  input  logic [5:0]           key_index_i,
  input  logic [31:0]          key_time_i,
  input  logic [31:0]          key_x_i,
  input  logic [31:0]          key_y_i,
  input  logic [31:0]          key_z_i,
  input  logic [31:0]          sample_time_i,
  output logic                 cmd_valid_o,
  output kvl_pkg::cmd_t        cmd_o,
  input  logic                 cmd_pop_i
);
  localparam int unsigned AW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  // One bit above the address so that MAX_KEYS itself can be represented.
  localparam int unsigned XW = (AW + 1 > kvl_pkg::IdxWidth) ? AW + 1 : kvl_pkg::IdxWidth;

  kvl_pkg::cmd_t   slot_q [2];
  kvl_pkg::cmd_t   in_cmd;
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;
  logic [XW-1:0]   idx_ext;

  assign idx_ext = XW'(key_index_i);

  always_comb begin
    in_cmd.is_sample = req_type_i;
    in_cmd.slot_ok   = idx_ext < XW'(MAX_KEYS);
    in_cmd.idx       = key_index_i;
    in_cmd.tm        = req_type_i ? sample_time_i : key_time_i;
    in_cmd.x         = key_x_i;
    in_cmd.y         = key_y_i;
    in_cmd.z         = key_z_i;
  end

  assign full_o      = cnt_q == 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = slot_q[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= in_cmd;
    end
  end
endmodule

FILE: rtl/kvl_div.sv
// Restoring divider giving sixteen fraction bits of num / den, one bit a cycle.
// Expects num < den. Depends on kvl_pkg.
`timescale 1ns / 1ps
module kvl_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [31:0]                      num_i,
  input  logic [31:0]                      den_i,
  output logic                             done_o,
  output logic [kvl_pkg::FracBits-1:0]     quo_o
);
  localparam int unsigned CW = $clog2(kvl_pkg::FracBits + 1);

  logic                          busy_q, done_q;
  logic [CW-1:0]                 cnt_q;
  logic [31:0]                   rem_q, den_q;
  logic [kvl_pkg::FracBits-1:0]  quo_q;
  logic [32:0]                   rem2;
  logic                          ge;

  assign rem2   = {rem_q, 1'b0};
  assign ge     = rem2 >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(kvl_pkg::FracBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
      quo_q <= {quo_q[kvl_pkg::FracBits-2:0], ge};
    end
  end
endmodule

FILE: rtl/kvl_back.sv
// Execution side: key memories, segment search, blend factor and interpolation.
// Depends on kvl_pkg and kvl_div.
`timescale 1ns / 1ps
module kvl_back #(
  parameter int unsigned MAX_KEYS = 64,
  localparam int unsigned NW = $clog2(MAX_KEYS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  kvl_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  input  logic [NW-1:0]  key_n_i,
  input  logic           pop_i,
  output logic           res_valid_o,
  output kvl_pkg::res_t  res_o
);
  localparam int unsigned AW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned XW = (AW > kvl_pkg::IdxWidth) ? AW : kvl_pkg::IdxWidth;
  localparam logic [16:0] One = 17'h10000;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SCAN = 10'b0000000010,
    ST_SCMP = 10'b0000000100,
    ST_LD0  = 10'b0000001000,
    ST_LD1  = 10'b0000010000,
    ST_LD2  = 10'b0000100000,
    ST_DIV  = 10'b0001000000,
    ST_MULA = 10'b0010000000,
    ST_MULB = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  scan_q, seg_q, rd_addr, wr_addr, nm2;
  logic [XW-1:0]  idx_ext;
  logic [1:0]     comp_q;
  logic           single_q, res_valid_q, wr_en;
  logic [31:0]    time_mem [MAX_KEYS];
  logic [31:0]    x_mem [MAX_KEYS];
  logic [31:0]    y_mem [MAX_KEYS];
  logic [31:0]    z_mem [MAX_KEYS];
  logic [31:0]    rd_tm_q;
  logic [31:0]    rd_v_q [3];
  logic [31:0]    t_q, t0_q;
  logic [31:0]    a_q [3];
  logic [31:0]    b_q [3];
  logic [31:0]    r_q [3];
  logic [16:0]    f_q;
  logic signed [50:0] prod_q;
  logic signed [32:0] diff;
  logic signed [50:0] rsum;
  logic           div_start, div_done;
  logic [15:0]    div_quo;
  kvl_pkg::res_t  res_q;

  assign idx_ext   = XW'(cmd_i.idx);
  assign wr_addr   = idx_ext[AW-1:0];
  assign nm2       = AW'(key_n_i - NW'(2));
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign wr_en     = cmd_pop_o && !cmd_i.is_sample && cmd_i.slot_ok;
  assign div_start = (state_q == ST_LD2) && !single_q && (rd_tm_q > t0_q)
                     && (t_q > t0_q) && (t_q < rd_tm_q);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    case (state_q)
      ST_SCAN: rd_addr = AW'(scan_q + AW'(1));
      ST_LD1:  rd_addr = AW'(seg_q + AW'(1));
      default: rd_addr = seg_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      time_mem[wr_addr] <= cmd_i.tm;
      x_mem[wr_addr]    <= cmd_i.x;
      y_mem[wr_addr]    <= cmd_i.y;
      z_mem[wr_addr]    <= cmd_i.z;
    end
    rd_tm_q   <= time_mem[rd_addr];
    rd_v_q[0] <= x_mem[rd_addr];
    rd_v_q[1] <= y_mem[rd_addr];
    rd_v_q[2] <= z_mem[rd_addr];
  end

  kvl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q - t0_q),
    .den_i   (rd_tm_q - t0_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // A single key blends with itself, so unwritten neighbours never reach the sum.
  assign diff = single_q ? 33'sd0
              : $signed({b_q[comp_q][31], b_q[comp_q]}) - $signed({a_q[comp_q][31], a_q[comp_q]});
  assign rsum = (prod_q + 51'sd32768) >>> kvl_pkg::FracBits;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_valid_i && cmd_i.is_sample) begin
        state_d = (key_n_i == NW'(1)) ? ST_LD0 : ST_SCAN;
      end
      ST_SCAN: state_d = ST_SCMP;
      ST_SCMP: begin
        if (t_q < rd_tm_q || scan_q == nm2) state_d = ST_LD0;
        else state_d = ST_SCAN;
      end
      ST_LD0:  state_d = ST_LD1;
      ST_LD1:  state_d = ST_LD2;
      ST_LD2:  state_d = div_start ? ST_DIV : ST_MULA;
      ST_DIV:  if (div_done) state_d = ST_MULA;
      ST_MULA: state_d = ST_MULB;
      ST_MULB: state_d = (comp_q == 2'd2) ? ST_OUT : ST_MULA;
      ST_OUT:  if (!res_valid_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      seg_q       <= '0;
      comp_q      <= 2'd0;
      single_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_i && res_valid_q) res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          scan_q   <= '0;
          seg_q    <= '0;
          comp_q   <= 2'd0;
          single_q <= key_n_i == NW'(1);
        end
        ST_SCMP: begin
          if (t_q < rd_tm_q) seg_q <= scan_q;
          else if (scan_q == nm2) seg_q <= nm2;
          else scan_q <= AW'(scan_q + AW'(1));
        end
        ST_MULB: comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        ST_OUT:  if (!res_valid_q) res_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (cmd_pop_o) t_q <= cmd_i.tm;
      ST_LD1: begin
        t0_q <= rd_tm_q;
        for (int i = 0; i < 3; i++) a_q[i] <= rd_v_q[i];
      end
      ST_LD2: begin
        for (int i = 0; i < 3; i++) b_q[i] <= rd_v_q[i];
        if (single_q || rd_tm_q <= t0_q || t_q <= t0_q) f_q <= '0;
        else if (t_q >= rd_tm_q) f_q <= One;
      end
      ST_DIV:  if (div_done) f_q <= {1'b0, div_quo};
      ST_MULA: prod_q <= 51'(diff * $signed({1'b0, f_q}));
      ST_MULB: r_q[comp_q] <= a_q[comp_q] + rsum[31:0];
      ST_OUT: if (!res_valid_q) begin
        res_q.x     <= r_q[0];
        res_q.y     <= r_q[1];
        res_q.z     <= r_q[2];
        res_q.seg   <= kvl_pkg::IdxWidth'(seg_q);
        res_q.blend <= f_q;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/keyframe_vector_lerp.sv
// Keyframe interpolator, top level: key count register, input queue, execution side.
// Depends on kvl_pkg, kvl_front and kvl_back.
`timescale 1ns / 1ps
// The block holds up to MAX_KEYS keyframes (time plus an x, y, z vector) and
// answers sample words with a linearly interpolated vector. A word with
// req_type_i low stores one keyframe and produces no result; a word with
// req_type_i high samples at sample_time_i and produces one result word
// carrying the vector, the start key of the segment used and the Q1.16 blend
// factor. Words are accepted into a two-word queue while full is low, and
// results wait in an output register until popped, so the input side keeps
// accepting while a result is held, until the queue is full. A keyframe write
// is taken while the execution side is idle and leaves it idle. A sample walks
// the time memory one key at a time until it finds the segment, and a
// fractional blend factor goes through the sixteen-step divider; the key
// search and the divider set the rate. The key count must be written
// through its own valid/ready channel only while the block is idle; the
// block itself does not enforce this. Zero reads as one and values above
// MAX_KEYS read as MAX_KEYS. Key times must ascend across the slots in use.
module keyframe_vector_lerp #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               req_type_i,
  input  logic [5:0]         key_index_i,
  input  logic [31:0]        key_time_i,
  input  logic signed [31:0] key_x_i,
  input  logic signed [31:0] key_y_i,
  input  logic signed [31:0] key_z_i,
  input  logic [31:0]        sample_time_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [5:0]         segment_o,
  output logic [16:0]        blend_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i
);
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);
  localparam int unsigned CW = (NW > kvl_pkg::CountWidth) ? NW : kvl_pkg::CountWidth;

  logic           cmd_valid, cmd_pop, res_valid;
  kvl_pkg::cmd_t  cmd;
  kvl_pkg::res_t  res;
  logic [NW-1:0]  key_n_q;
  logic [CW-1:0]  cfg_ext;

  // The register is always ready; the value is clamped on the way in.
  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = CW'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_n_q <= NW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_ext == '0) key_n_q <= NW'(1);
      else if (cfg_ext > CW'(MAX_KEYS)) key_n_q <= NW'(MAX_KEYS);
      else key_n_q <= NW'(cfg_ext);
    end
  end

  kvl_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .key_index_i   (key_index_i),
    .key_time_i    (key_time_i),
    .key_x_i       (key_x_i),
    .key_y_i       (key_y_i),
    .key_z_i       (key_z_i),
    .sample_time_i (sample_time_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  kvl_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .key_n_i     (key_n_q),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty     = !res_valid;
  assign out_x_o   = res.x;
  assign out_y_o   = res.y;
  assign out_z_o   = res.z;
  assign segment_o = res.seg;
  assign blend_o   = res.blend;
endmodule

FILE: rtl/kvl_checker.sv
// Port-level checker for the keyframe interpolator, bound to the top level.
// Depends on keyframe_vector_lerp_assert.svh.
`timescale 1ns / 1ps
`include "keyframe_vector_lerp_assert.svh"
module kvl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_x_o,
  input logic [16:0] blend_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);
  `KVL_ASSERT_NEXT(a_res_held, !empty && !pop, !empty)
  `KVL_ASSERT_NEXT(a_res_stable, !empty && !pop, $stable(out_x_o) && $stable(blend_o))
  `KVL_ASSERT_NOW(a_blend_range, !empty, blend_o <= 17'h10000)
  `KVL_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)
endmodule

bind keyframe_vector_lerp kvl_checker u_kvl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .out_x_o     (out_x_o),
  .blend_o     (blend_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the keyframe_vector_lerp block.
// Depends on kvl_pkg and the keyframe_vector_lerp RTL; reads no files.
`timescale 1ns / 1ps

// Keeps its own copy of the key tables and the key count, predicts the result
// word of every accepted sample and compares popped words in order.
class lerp_scoreboard;
  logic [31:0] key_time_tab[64];
  logic signed [31:0] key_x_tab[64];
  logic signed [31:0] key_y_tab[64];
  logic signed [31:0] key_z_tab[64];
  int unsigned keys_in_use;
  kvl_pkg::res_t pending_q[$];
  int errors;
  int samples_checked;

  function new();
    keys_in_use = 1;
    errors = 0;
    samples_checked = 0;
    for (int i = 0; i < 64; i++) begin
      key_time_tab[i] = '0;
      key_x_tab[i] = '0;
      key_y_tab[i] = '0;
      key_z_tab[i] = '0;
    end
  endfunction

  function void set_key_count(logic [6:0] cnt);
    keys_in_use = cnt;
    if (keys_in_use < 1) keys_in_use = 1;
    if (keys_in_use > 64) keys_in_use = 64;
  endfunction

  // Rounds to nearest, ties upward; the result lies between a and b.
  function logic [31:0] blend_component(logic signed [31:0] a, logic signed [31:0] b,
                                        logic [16:0] f);
    longint diff, prod, q;
    diff = longint'(b) - longint'(a);
    prod = diff * longint'({1'b0, f}) + 32768;
    q = prod >>> 16;
    return 32'(longint'(a) + q);
  endfunction

  function void note_word(logic req, logic [5:0] idx, logic [31:0] kt,
                          logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                          logic [31:0] st);
    kvl_pkg::res_t r;
    int unsigned seg;
    logic [31:0] t0, t1;
    logic [16:0] f;
    logic [63:0] num;
    if (!req) begin
      key_time_tab[idx] = kt;
      key_x_tab[idx] = kx;
      key_y_tab[idx] = ky;
      key_z_tab[idx] = kz;
      return;
    end
    if (keys_in_use == 1) begin
      r.x = key_x_tab[0];
      r.y = key_y_tab[0];
      r.z = key_z_tab[0];
      r.seg = '0;
      r.blend = '0;
    end else begin
      // Past the last key the last segment is taken.
      seg = keys_in_use - 2;
      for (int i = 0; i + 1 < keys_in_use; i++)
        if (st < key_time_tab[i + 1]) begin
          seg = i;
          break;
        end
      t0 = key_time_tab[seg];
      t1 = key_time_tab[seg + 1];
      if (t1 <= t0 || st <= t0) f = '0;
      else if (st >= t1) f = 17'd65536;
      else begin
        num = 64'(st - t0) << 16;
        num = num / 64'(t1 - t0);
        f = (num > 65536) ? 17'd65536 : num[16:0];
      end
      r.x = blend_component(key_x_tab[seg], key_x_tab[seg + 1], f);
      r.y = blend_component(key_y_tab[seg], key_y_tab[seg + 1], f);
      r.z = blend_component(key_z_tab[seg], key_z_tab[seg + 1], f);
      r.seg = 6'(seg);
      r.blend = f;
    end
    pending_q = {pending_q, r};
  endfunction

  function void check_word(kvl_pkg::res_t got);
    kvl_pkg::res_t exp_w;
    if (pending_q.size() == 0) begin
      $display("%0t: result word with none expected, got %h", $realtime, got);
      errors++;
      return;
    end
    exp_w = pending_q.pop_front();
    samples_checked++;
    if (got.x !== exp_w.x) begin
      $display("%0t: out_x expected %h actual %h", $realtime, exp_w.x, got.x);
      errors++;
    end
    if (got.y !== exp_w.y) begin
      $display("%0t: out_y expected %h actual %h", $realtime, exp_w.y, got.y);
      errors++;
    end
    if (got.z !== exp_w.z) begin
      $display("%0t: out_z expected %h actual %h", $realtime, exp_w.z, got.z);
      errors++;
    end
    if (got.seg !== exp_w.seg) begin
      $display("%0t: segment expected %0d actual %0d", $realtime, exp_w.seg, got.seg);
      errors++;
    end
    if (got.blend !== exp_w.blend) begin
      $display("%0t: blend expected %0d actual %0d", $realtime, exp_w.blend, got.blend);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic req_type_i;
  logic [5:0] key_index_i;
  logic [31:0] key_time_i;
  logic signed [31:0] key_x_i, key_y_i, key_z_i;
  logic [31:0] sample_time_i;
  logic empty;
  logic pop;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic [5:0] segment_o;
  logic [16:0] blend_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i;

  lerp_scoreboard sb;
  // While set, neither side idles, so words flow back to back.
  bit no_idle;
  int unsigned words_sent;
  int unsigned cfg_writes;
  int unsigned cur_keys;

  keyframe_vector_lerp dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .req_type_i(req_type_i), .key_index_i(key_index_i), .key_time_i(key_time_i),
    .key_x_i(key_x_i), .key_y_i(key_y_i), .key_z_i(key_z_i),
    .sample_time_i(sample_time_i),
    .empty(empty), .pop(pop),
    .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o),
    .segment_o(segment_o), .blend_o(blend_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: pop at random, and check every word taken at an edge.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty)
        sb.check_word({out_x_o, out_y_o, out_z_o, segment_o, blend_o});
      pop <= no_idle || ($urandom_range(99) >= 17);
    end
  end

  // Offers one word and holds it until the block takes it. Idle cycles are
  // inserted beforehand with push low, so valid never drops mid-offer. Push
  // stays high after acceptance; the next offer or the caller lowers it.
  task automatic send_word(logic req, logic [5:0] idx, logic [31:0] kt,
                           logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                           logic [31:0] st);
    while (!no_idle && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= req;
    key_index_i <= idx;
    key_time_i <= kt;
    key_x_i <= kx;
    key_y_i <= ky;
    key_z_i <= kz;
    sample_time_i <= st;
    do @(posedge clk_i); while (full);
    sb.note_word(req, idx, kt, kx, ky, kz, st);
    words_sent++;
  endtask

  task automatic write_key(int idx, logic [31:0] kt, logic [31:0] kx, logic [31:0] ky,
                           logic [31:0] kz);
    send_word(1'b0, 6'(idx), kt, kx, ky, kz, $urandom());
  endtask

  task automatic sample_at(logic [31:0] st);
    send_word(1'b1, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(), st);
  endtask

  // Drains every expected word, lets the execution side settle after any
  // trailing keyframe write, then writes the key count.
  task automatic set_keys(logic [6:0] cnt);
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_key_count(cnt);
    cfg_writes++;
    cur_keys = (cnt == 0) ? 1 : (cnt > 64) ? 64 : cnt;
  endtask

  // Fills slots 0..n-1 with ascending times; gaps are sometimes zero so
  // that equal neighbouring times are hit.
  task automatic load_table(int n, logic [31:0] step_max);
    logic [31:0] t;
    t = $urandom_range(1000);
    for (int i = 0; i < n; i++) begin
      write_key(i, t, $urandom(), $urandom(), $urandom());
      t = t + (($urandom_range(9) == 0) ? 0 : $urandom_range(step_max, 1));
    end
  endtask

  function automatic logic [31:0] pick_time();
    logic [31:0] lo, hi;
    lo = sb.key_time_tab[0];
    hi = sb.key_time_tab[cur_keys - 1];
    case ($urandom_range(9))
      0: return $urandom_range(lo);
      1: return hi + $urandom_range(500);
      2: return sb.key_time_tab[$urandom_range(cur_keys - 1)];
      3: return $urandom();
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  initial begin
    int n;
    sb = new();
    no_idle = 1'b0;
    words_sent = 0;
    cfg_writes = 0;
    cur_keys = 1;
    rst_ni = 1'b0;
    push = 1'b0;
    req_type_i = 1'b0;
    key_index_i = '0;
    key_time_i = '0;
    key_x_i = '0;
    key_y_i = '0;
    key_z_i = '0;
    sample_time_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: single key, extreme values, clamps and equal times.
    write_key(0, 32'd100, 32'h7fffffff, 32'h80000000, 32'h0);
    sample_at(32'd0);
    sample_at(32'hffffffff);
    set_keys(7'd0);
    sample_at(32'd5);
    write_key(1, 32'd100, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    write_key(2, 32'hffffffff, 32'h00010000, 32'hfffeffff, 32'h7fffffff);
    write_key(63, 32'hffffffff, 32'h1234, 32'h5678, 32'h9abc);
    set_keys(7'd3);
    sample_at(32'd0);          // before the first key
    sample_at(32'd100);        // equal times at slots 0 and 1
    sample_at(32'h80000000);   // inside the long segment
    sample_at(32'hfffffffe);
    sample_at(32'hffffffff);   // at the last key
    write_key(1, 32'd300, 32'h80000000, 32'h7fffffff, 32'h1);
    sample_at(32'd200);
    sample_at(32'd299);
    sample_at(32'd101);

    // Random phases, with the key count swept from small to its extremes.
    while (words_sent < 1450) begin
      case ($urandom_range(5))
        0: n = 2;
        1: n = 64;
        2: n = 127;
        default: n = $urandom_range(12, 1);
      endcase
      no_idle = ($urandom_range(4) == 0);
      set_keys(7'(n));
      load_table(cur_keys, ($urandom_range(1)) ? 32'd300 : 32'h00ffffff);
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(19) == 0)
          write_key($urandom_range(cur_keys - 1), sb.key_time_tab[0],
                    $urandom(), $urandom(), $urandom());
        else
          sample_at(pick_time());
      end
    end
    no_idle = 1'b0;
    push <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d words with %0d key count writes; %0d sample results checked.",
             words_sent, cfg_writes, sb.samples_checked);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400ms;
    $display("Timeout with %0d results outstanding.", sb.pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
